### rtl/sliding_window_sender_defines.svh
// Assertion macros used by the checker file.
`ifndef SLIDING_WINDOW_SENDER_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sws_pkg.sv
`default_nettype none
package sws_pkg;
  localparam int WINDOW        = 5;
  localparam int SEGMENT_BYTES = 128;
  localparam int RING_SLOTS    = 16;
  localparam int SEQ_STEP      = SEGMENT_BYTES + 1;
  localparam int RING_W        = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int SLOT_W        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CFG_IDX_W     = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_ACK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_BYTES = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_STARTED    = 3'd0;
  localparam logic [2:0] KIND_TRANSMIT   = 3'd1;
  localparam logic [2:0] KIND_RETRANSMIT = 3'd2;
  localparam logic [2:0] KIND_ACK_OK     = 3'd3;
  localparam logic [2:0] KIND_ACK_IGNORE = 3'd4;
  localparam logic [2:0] KIND_ACK_ERROR  = 3'd5;
  localparam logic [2:0] KIND_FULL       = 3'd6;
  localparam logic [2:0] KIND_NO_RESEND  = 3'd7;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_SEND    = 2'd1,
    CMD_ACK     = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  bytes;
    logic [31:0] ack_value;
    logic        ack_is_last;
  } sws_cmd_t;
endpackage
`default_nettype wire

### rtl/sws_in_if.sv
`default_nettype none
interface sws_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  segment_bytes;
  logic [31:0] ack_value;
  logic        ack_is_last;
  modport source (output valid, command, segment_bytes, ack_value, ack_is_last, input ready);
  modport sink (input valid, command, segment_bytes, ack_value, ack_is_last, output ready);
endinterface
`default_nettype wire

### rtl/sws_out_if.sv
`default_nettype none
interface sws_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] seq_number;
  logic [3:0]  ring_position;
  logic [7:0]  data_bytes;
  logic        last_segment;
  logic        transfer_done;
  logic        final_item;
  modport source (output valid, kind, seq_number, ring_position, data_bytes, last_segment,
                  transfer_done, final_item, input ready);
  modport sink (input valid, kind, seq_number, ring_position, data_bytes, last_segment,
                transfer_done, final_item, output ready);
endinterface
`default_nettype wire

### rtl/sws_cfg_if.sv
`default_nettype none
interface sws_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sws_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/sws_front.sv
`default_nettype none
module sws_front (
  input  wire logic        clk,
  input  wire logic        rst,
  sws_in_if.sink           in_ch,
  output sws_pkg::sws_cmd_t cmd_out,
  output logic             cmd_valid,
  input  wire logic        cmd_pop
);
  sws_pkg::sws_cmd_t queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  sws_pkg::sws_cmd_t classified;

  // Decode the command and clamp oversized segments.
  always_comb begin
    classified.cmd         = sws_pkg::cmd_t'(in_ch.command);
    classified.bytes       = (32'(in_ch.segment_bytes) > 32'(sws_pkg::SEGMENT_BYTES)) ?
                             8'(sws_pkg::SEGMENT_BYTES) : in_ch.segment_bytes;
    classified.ack_value   = in_ch.ack_value;
    classified.ack_is_last = in_ch.ack_is_last;
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count != 2'd0);
  assign cmd_out     = queue[rd_ptr];

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classified;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end
endmodule
`default_nettype wire

### rtl/sws_back.sv
`default_nettype none
module sws_back (
  input  wire logic         clk,
  input  wire logic         rst,
  sws_cfg_if.sink           cfg,
  input  sws_pkg::sws_cmd_t cmd_in,
  input  wire logic         cmd_valid,
  output logic              cmd_pop,
  sws_out_if.source         out_ch
);
  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t            state;
  sws_pkg::sws_cmd_t cur;
  logic [31:0]       start_seq;
  logic [23:0]       file_bytes;
  logic [31:0]       last_seq;
  logic [31:0]       next_seq;
  logic [31:0]       expected_ack;
  logic [sws_pkg::RING_W-1:0] ring_index;
  logic              done_flag;
  logic [sws_pkg::WINDOW-1:0] slot_free;
  logic [sws_pkg::WINDOW-1:0] pending;
  logic [31:0]       slot_seq  [sws_pkg::WINDOW];
  logic [7:0]        slot_size [sws_pkg::WINDOW];
  logic [sws_pkg::RING_W-1:0] slot_pos [sws_pkg::WINDOW];
  logic              slot_last [sws_pkg::WINDOW];

  logic              emit;
  logic [23:0]       segs_m1;
  logic              free_found;
  logic [sws_pkg::SLOT_W-1:0] free_idx;
  logic              ack_match;
  logic              ack_found;
  logic [sws_pkg::SLOT_W-1:0] ack_idx;
  logic [sws_pkg::WINDOW-1:0] pick;
  logic [sws_pkg::SLOT_W-1:0] pick_idx;

  assign cfg.ready = 1'b1;
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;
  assign emit      = (state == ST_EXEC) && (!out_ch.valid || out_ch.ready);
  assign segs_m1   = (file_bytes == 24'd0) ? 24'd0 :
                     24'((file_bytes - 24'd1) / sws_pkg::SEGMENT_BYTES);

  // Lowest free window slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < sws_pkg::WINDOW; i++) begin
      if (slot_free[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = sws_pkg::SLOT_W'(i);
      end
    end
  end

  // Occupied slot that this ack closes.
  always_comb begin
    ack_match = (cur.ack_value == expected_ack);
    ack_found = 1'b0;
    ack_idx   = '0;
    for (int i = 0; i < sws_pkg::WINDOW; i++) begin
      if (!slot_free[i] && !ack_found &&
          (slot_seq[i] + 32'(slot_size[i]) + 32'd1 == cur.ack_value)) begin
        ack_found = 1'b1;
        ack_idx   = sws_pkg::SLOT_W'(i);
      end
    end
  end

  // Pending slot with the smallest sequence, lower slot first on ties.
  always_comb begin
    pick     = pending;
    pick_idx = '0;
    for (int i = 0; i < sws_pkg::WINDOW; i++) begin
      for (int j = 0; j < sws_pkg::WINDOW; j++) begin
        if (j != i && pending[j] &&
            (slot_seq[j] < slot_seq[i] || (slot_seq[j] == slot_seq[i] && j < i))) begin
          pick[i] = 1'b0;
        end
      end
    end
    for (int i = 0; i < sws_pkg::WINDOW; i++) begin
      if (pick[i]) pick_idx = sws_pkg::SLOT_W'(i);
    end
  end

  // Slot payload storage, no reset.
  always_ff @(posedge clk) begin
    if (emit && cur.cmd == sws_pkg::CMD_SEND && free_found) begin
      slot_seq[free_idx]  <= next_seq;
      slot_size[free_idx] <= cur.bytes;
      slot_pos[free_idx]  <= ring_index;
      slot_last[free_idx] <= (next_seq == last_seq);
    end
    last_seq <= start_seq + 32'(segs_m1) * 32'(sws_pkg::SEQ_STEP);
  end

  // Configuration registers, command sequencer, window bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      start_seq    <= '0;
      file_bytes   <= 24'd1;
      next_seq     <= '0;
      expected_ack <= '0;
      ring_index   <= '0;
      done_flag    <= 1'b0;
      slot_free    <= '1;
      pending      <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          sws_pkg::REG_START_SEQ:  start_seq  <= cfg.data;
          sws_pkg::REG_FILE_BYTES: file_bytes <= cfg.data[23:0];
          default: ;
        endcase
      end
      if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur     <= cmd_in;
            pending <= ~slot_free;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (emit) begin
            out_ch.valid         <= 1'b1;
            out_ch.kind          <= sws_pkg::KIND_STARTED;
            out_ch.seq_number    <= '0;
            out_ch.ring_position <= '0;
            out_ch.data_bytes    <= '0;
            out_ch.last_segment  <= 1'b0;
            out_ch.transfer_done <= done_flag;
            out_ch.final_item    <= 1'b1;
            state                <= ST_IDLE;
            case (cur.cmd)
              sws_pkg::CMD_START: begin
                next_seq             <= start_seq;
                expected_ack         <= start_seq + 32'(sws_pkg::SEQ_STEP);
                ring_index           <= '0;
                done_flag            <= 1'b0;
                slot_free            <= '1;
                out_ch.seq_number    <= start_seq;
                out_ch.transfer_done <= 1'b0;
              end
              sws_pkg::CMD_SEND: begin
                if (!free_found) begin
                  out_ch.kind <= sws_pkg::KIND_FULL;
                end else begin
                  slot_free[free_idx]  <= 1'b0;
                  out_ch.kind          <= sws_pkg::KIND_TRANSMIT;
                  out_ch.seq_number    <= next_seq;
                  out_ch.ring_position <= 4'(ring_index);
                  out_ch.data_bytes    <= cur.bytes;
                  out_ch.last_segment  <= (next_seq == last_seq);
                  next_seq             <= next_seq + 32'd1 + 32'(cur.bytes);
                  ring_index           <= (32'(ring_index) == sws_pkg::RING_SLOTS - 1) ?
                                          '0 : ring_index + 1'b1;
                end
              end
              sws_pkg::CMD_ACK: begin
                expected_ack <= expected_ack + 32'(sws_pkg::SEQ_STEP);
                if (cur.ack_is_last) begin
                  done_flag            <= 1'b1;
                  out_ch.transfer_done <= 1'b1;
                end
                if (!ack_match) begin
                  out_ch.kind <= sws_pkg::KIND_ACK_IGNORE;
                end else if (!ack_found) begin
                  out_ch.kind <= sws_pkg::KIND_ACK_ERROR;
                end else begin
                  slot_free[ack_idx]   <= 1'b1;
                  out_ch.kind          <= sws_pkg::KIND_ACK_OK;
                  out_ch.seq_number    <= slot_seq[ack_idx];
                  out_ch.ring_position <= 4'(slot_pos[ack_idx]);
                  out_ch.data_bytes    <= slot_size[ack_idx];
                  out_ch.last_segment  <= slot_last[ack_idx];
                end
              end
              default: begin
                if (pending == '0) begin
                  out_ch.kind <= sws_pkg::KIND_NO_RESEND;
                end else begin
                  pending              <= pending & ~pick;
                  out_ch.kind          <= sws_pkg::KIND_RETRANSMIT;
                  out_ch.seq_number    <= slot_seq[pick_idx];
                  out_ch.ring_position <= 4'(slot_pos[pick_idx]);
                  out_ch.data_bytes    <= slot_size[pick_idx];
                  out_ch.last_segment  <= slot_last[pick_idx];
                  out_ch.final_item    <= ((pending & ~pick) == '0);
                  if ((pending & ~pick) != '0) state <= ST_EXEC;
                end
              end
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/sliding_window_sender.sv
// Sliding window sender: transmit-side window bookkeeping of a segmented transfer.
// Channels: in_ch takes commands (start, send, ack, timeout), out_ch returns
// results, cfg writes start_seq (0) and file_bytes (2); peer_ack (1) is ignored.
// All channels use valid/ready; a transaction completes when both are high.
// Each command yields one result, except a timeout, which yields one
// retransmit per occupied window slot in ascending sequence order.
// final_item marks the last result of a command.
// A command enters a two-entry queue, is taken into the sequencer's command
// register and its first result is then registered in the output register.
// The sequencer works on one command at a time and takes the next only after
// it has registered the last result of the current one.
// Reset (synchronous rst) clears counters, frees the window and empties the
// queue and the output register. Slot contents are not cleared.
// When the receiver stalls, the result register holds and the sequencer waits;
// the command queue keeps accepting until its two entries are full.
`default_nettype none
module sliding_window_sender (
  input  wire logic clk,
  input  wire logic rst,
  sws_in_if.sink    in_ch,
  sws_out_if.source out_ch,
  sws_cfg_if.sink   cfg
);
  sws_pkg::sws_cmd_t cmd;
  logic              cmd_valid;
  logic              cmd_pop;

  // Command intake and classification.
  sws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd_out   (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // Window state and result sequencing.
  sws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_in    (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

### rtl/sws_checker.sv
`default_nettype none
`include "sliding_window_sender_defines.svh"
module sws_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_kind,
  input wire logic [31:0] out_seq,
  input wire logic       out_done,
  input wire logic       out_final
);
  // A stalled result holds valid.
  `SWS_ASSERT(a_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  // A stalled result holds its sequence number.
  `SWS_ASSERT(a_stable, out_valid && !out_ready |=> $stable(out_seq), "result changed while stalled")
  // Reset empties the result register.
  `SWS_ASSERT_ALWAYS(a_rst, rst |=> !out_valid, "result present after reset")
  // A start answer ends its command and reports an open transfer.
  `SWS_ASSERT(a_start, out_valid && out_kind == sws_pkg::KIND_STARTED |-> out_final && !out_done, "bad start result")
endmodule

bind sliding_window_sender sws_checker u_sws_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_seq   (out_ch.seq_number),
  .out_done  (out_ch.transfer_done),
  .out_final (out_ch.final_item)
);
`default_nettype wire
